@@ src/bzp_pkg.sv @@
// ----------------------------------------------------------------------------
// bzp_pkg
// Shared types, codes and timing constants for the buzzer pattern generator.
// ----------------------------------------------------------------------------
package bzp_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_PAT = 2'd1,
        OP_SILENCE = 2'd2,
        OP_CHIRP   = 2'd3
    } op_t;

    // Pattern codes (code 7 means nothing and is ignored)
    localparam logic [2:0] PAT_NONE     = 3'd0;
    localparam logic [2:0] PAT_SHORT    = 3'd1;
    localparam logic [2:0] PAT_RUN      = 3'd2;
    localparam logic [2:0] PAT_FULL     = 3'd3;
    localparam logic [2:0] PAT_ERROR    = 3'd4;
    localparam logic [2:0] PAT_LATCHED  = 3'd5;
    localparam logic [2:0] PAT_OVERFLOW = 3'd6;

    localparam int PAT_W   = 3;
    localparam int MS_W    = 16;
    localparam int DUTY_W  = 8;
    localparam int OP_W    = 2;

    localparam logic [DUTY_W-1:0] TONE_DUTY_RST = 8'd128;
    localparam logic [MS_W-1:0]   PHASE_MAX     = 16'hFFFF;

    // Pattern periods in ms; zero means a saturating count
    localparam logic [MS_W-1:0] PER_RUN      = 16'd60000;
    localparam logic [MS_W-1:0] PER_FULL     = 16'd600;
    localparam logic [MS_W-1:0] PER_ERROR    = 16'd1000;
    localparam logic [MS_W-1:0] PER_LATCHED  = 16'd400;
    localparam logic [MS_W-1:0] PER_OVERFLOW = 16'd250;

    // On-time edges in ms
    localparam logic [MS_W-1:0] ON_SHORT     = 16'd100;
    localparam logic [MS_W-1:0] ON_RUN_A     = 16'd400;
    localparam logic [MS_W-1:0] ON_RUN_B_LO  = 16'd600;
    localparam logic [MS_W-1:0] ON_RUN_B_HI  = 16'd720;
    localparam logic [MS_W-1:0] ON_FULL      = 16'd300;
    localparam logic [MS_W-1:0] ON_ERROR     = 16'd100;
    localparam logic [MS_W-1:0] ON_LATCHED   = 16'd200;
    localparam logic [MS_W-1:0] ON_OVERFLOW  = 16'd125;

    function automatic logic [MS_W-1:0] period_of(input logic [PAT_W-1:0] pat);
        logic [MS_W-1:0] per;
        case (pat)
            PAT_RUN:      per = PER_RUN;
            PAT_FULL:     per = PER_FULL;
            PAT_ERROR:    per = PER_ERROR;
            PAT_LATCHED:  per = PER_LATCHED;
            PAT_OVERFLOW: per = PER_OVERFLOW;
            default:      per = '0;
        endcase
        return per;
    endfunction

endpackage

@@ src/buzzer_pattern_generator_top.sv @@
// ----------------------------------------------------------------------------
// buzzer_pattern_generator_top
// Alarm buzzer pattern engine: ticks, pattern requests, silence and chirps.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns one result item for
// each. An accepted item lands in an input register; once the result
// register is free, a single pass of counter, compare and select logic
// updates the pattern state and loads the result register. Throughput is
// one item per cycle for as long as the result side keeps taking items; a
// stalled result register holds the input register, and the input
// register holds s_tready low once both are full.
// Each item carries its operation in s_tuser: a 1 ms tick advances the
// pattern phase and recomputes the duty, a set-pattern request restarts the
// phase only when the pattern changes, silence drops the duty to zero at
// once, and a chirp loads a millisecond count that forces the tone on for
// the following ticks. The user writes tone_duty via cfg_wr_en/cfg_wr_data only
// while the block is idle, which is not enforced; it resets to 128 (half duty).
// ----------------------------------------------------------------------------
module buzzer_pattern_generator_top
    import bzp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // tone_duty

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [2:0] pattern, [18:3] chirp_ms, rest zero
    input  logic [1:0]  s_tuser,       // [1:0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [7:0] duty, [10:8] pattern_now,
                                       // [11] chirp_active, rest zero
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] tone_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_duty_reg <= TONE_DUTY_RST;
        end else if (cfg_wr_en) begin
            tone_duty_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or taken; the input
    // register advances whenever the result register can take its item.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [PAT_W-1:0]  in_pat_reg;
    logic [MS_W-1:0]   in_ms_reg;

    logic              out_valid_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [PAT_W-1:0]  out_pat_reg;
    logic              out_chirp_reg;

    logic out_free;
    logic advance;
    logic s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture the payload only on accept; hold it otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg  <= op_t'(s_tuser[OP_W-1:0]);
            in_pat_reg <= s_tdata[PAT_W-1:0];
            in_ms_reg  <= s_tdata[PAT_W +: MS_W];
        end
    end

    // ------------------------------------------------------------------
    // Pattern state
    // ------------------------------------------------------------------
    logic [PAT_W-1:0]  pattern_reg,   pattern_next;
    logic [MS_W-1:0]   phase_reg,     phase_next;
    logic              muted_reg,     muted_next;
    logic [MS_W-1:0]   chirp_reg,     chirp_next;
    logic [DUTY_W-1:0] duty_reg,      duty_next;

    // Tick datapath, worked out alongside the other operations
    logic [MS_W-1:0]   period;
    logic [MS_W-1:0]   chirp_dec;
    logic [MS_W-1:0]   phase_inc;
    logic [MS_W-1:0]   phase_tick;
    logic              tone_on;
    logic              short_expired;

    assign period    = period_of(pattern_reg);
    assign chirp_dec = (chirp_reg != '0) ? chirp_reg - 1'b1 : chirp_reg;
    assign phase_inc = phase_reg + 1'b1;

    always_comb begin
        // Wrap at the period, or saturate for the patterns without one
        if (period == '0) begin
            phase_tick = (phase_reg != PHASE_MAX) ? phase_inc : phase_reg;
        end else begin
            phase_tick = ({1'b0, phase_reg} + 1'b1 >= {1'b0, period}) ? '0 : phase_inc;
        end
    end

    // Decide the tone from the advanced phase
    always_comb begin
        tone_on       = 1'b0;
        short_expired = 1'b0;
        case (pattern_reg)
            PAT_SHORT: begin
                tone_on       = phase_tick < ON_SHORT;
                short_expired = phase_tick > ON_SHORT;
            end
            PAT_RUN:      tone_on = (phase_tick < ON_RUN_A) ||
                                    (phase_tick >= ON_RUN_B_LO && phase_tick < ON_RUN_B_HI);
            PAT_FULL:     tone_on = phase_tick < ON_FULL;
            PAT_ERROR:    tone_on = phase_tick < ON_ERROR;
            PAT_LATCHED:  tone_on = phase_tick < ON_LATCHED;
            PAT_OVERFLOW: tone_on = phase_tick < ON_OVERFLOW;
            default:      tone_on = 1'b0;
        endcase
    end

    always_comb begin
        pattern_next = pattern_reg;
        phase_next   = phase_reg;
        muted_next   = muted_reg;
        chirp_next   = chirp_reg;
        duty_next    = duty_reg;
        unique case (in_op_reg)
            OP_TICK: begin
                chirp_next = chirp_dec;
                phase_next = phase_tick;
                if (chirp_dec != '0) begin
                    // Chirp overrides pattern and silence; short does not revert
                    duty_next = tone_duty_reg;
                end else begin
                    if (short_expired) begin
                        pattern_next = PAT_NONE;
                    end
                    duty_next = (tone_on && !muted_reg) ? tone_duty_reg : '0;
                end
            end
            OP_SET_PAT: begin
                // Drop the unused code and repeats of the running pattern
                if (in_pat_reg <= PAT_OVERFLOW && in_pat_reg != pattern_reg) begin
                    pattern_next = in_pat_reg;
                    phase_next   = '0;
                    muted_next   = 1'b0;
                end
            end
            OP_SILENCE: begin
                muted_next = 1'b1;
                duty_next  = '0;
            end
            OP_CHIRP: begin
                chirp_next = in_ms_reg;
            end
            default: begin
                chirp_next = chirp_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PAT_NONE;
            phase_reg   <= '0;
            muted_reg   <= 1'b0;
            chirp_reg   <= '0;
            duty_reg    <= '0;
        end else if (advance) begin
            pattern_reg <= pattern_next;
            phase_reg   <= phase_next;
            muted_reg   <= muted_next;
            chirp_reg   <= chirp_next;
            duty_reg    <= duty_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_duty_reg  <= duty_next;
            out_pat_reg   <= pattern_next;
            out_chirp_reg <= (chirp_next != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_chirp_reg, out_pat_reg, out_duty_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A waiting result mirrors the state it was taken from
    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] == (chirp_reg != '0)) && (m_tdata[10:8] == pattern_reg)
        && (m_tdata[7:0] == duty_reg))
        else $error("result register out of step with pattern state");

    // Wrapping patterns keep their phase inside the period
    a_phase_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (period != '0) |-> (phase_reg < period))
        else $error("phase beyond the pattern period");

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // A completed result handshake frees the result register for the next item
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !in_valid_reg) |=> !m_tvalid)
        else $error("result repeated after hand-off");

endmodule
